/* hdl/btpc_pkg.sv */
// Shared types and helpers for the barometric compensation core.
// No dependencies.
package btpc_pkg;

    typedef enum logic [4:0] {
        S_IDLE,
        S_T0, S_T1, S_T2, S_T3, S_T4,
        S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8,
        S_P9, S_P10, S_P11, S_P12, S_P13,
        S_MUL, S_DIV, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        REG_CALIB_TEMP   = 3'd0,
        REG_CALIB_PRESS1 = 3'd1,
        REG_CALIB_PRESS2 = 3'd2,
        REG_CALIB_PRESS9 = 3'd3,
        REG_TEMP_EN      = 3'd4,
        REG_PRESS_EN     = 3'd5
    } t_reg_index;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_DISABLED = 2'd1;
    localparam logic [1:0] STATUS_DIV_ZERO = 2'd2;

    localparam logic       KIND_TEMP  = 1'b0;
    localparam logic       KIND_PRESS = 1'b1;

    localparam logic [63:0] FINE_OFFSET = 64'd128000;
    localparam logic [63:0] ADC_FULL    = 64'd1048576;
    localparam logic [63:0] PRESS_SCALE = 64'd3125;

    function automatic logic [63:0] f_sext16(input logic [15:0] x);
        return {{48{x[15]}}, x};
    endfunction

endpackage

/* hdl/baro_temp_pressure_compensation_core.sv */
// Barometric temperature/pressure integer compensation core.
// A result is valid once its chain of products and, for pressure with a nonzero divisor,
// the divide are done, plus any output stall; the bit-serial shift-add multiplier stops
// early once the multiplier runs out of ones, and the divider is a 64-step restoring one.
// A disabled channel skips to output. One request at a time; the next is taken in the cycle
// after its result loads, while it waits. Sync active-low reset clears calibration and fine temp.
module baro_temp_pressure_compensation_core
    import btpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [23:0] raw_reading
    input  logic        s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [31:0] temperature_centi, [63:32] pressure_q24_8,
                                   // [65:64] status, rest zero
    output logic        m_tuser    // [0] kind
);

    t_state      r_state, n_state, r_ret, n_ret;

    logic [47:0] r_cal_t;
    logic [63:0] r_cal_p1, r_cal_p2;
    logic [15:0] r_cal_p9;
    logic        r_temp_en, r_press_en;
    logic [31:0] r_fine;

    logic [19:0] r_adc;
    logic        r_kind;
    logic [31:0] r_res_t, r_res_p;
    logic [1:0]  r_res_st;

    logic [63:0] r_ma, r_mb, r_prod;
    logic [63:0] r_rem, r_quo, r_dv;
    logic        r_qneg;
    logic [5:0]  r_cnt;
    logic [63:0] r_v1, r_v2, r_sq, r_x, r_p;

    logic        r_out_valid;
    logic [31:0] r_out_t, r_out_p;
    logic [1:0]  r_out_st;
    logic        r_out_kind;

    logic        s_accept;
    logic        out_load;
    logic [64:0] rem_sh;
    logic        div_ge;
    logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] adc64, v1_init, p6_v1, num_base, final_p, t5;
    logic [63:0] prod_asr14, prod_asr19, p_sum;

    assign t1 = {48'd0, r_cal_t[15:0]};
    assign t2 = f_sext16(r_cal_t[31:16]);
    assign t3 = f_sext16(r_cal_t[47:32]);
    assign p1 = {48'd0, r_cal_p1[15:0]};
    assign p2 = f_sext16(r_cal_p1[31:16]);
    assign p3 = f_sext16(r_cal_p1[47:32]);
    assign p4 = f_sext16(r_cal_p1[63:48]);
    assign p5 = f_sext16(r_cal_p2[15:0]);
    assign p6 = f_sext16(r_cal_p2[31:16]);
    assign p7 = f_sext16(r_cal_p2[47:32]);
    assign p8 = f_sext16(r_cal_p2[63:48]);
    assign p9 = f_sext16(r_cal_p9);

    assign adc64      = {44'd0, r_adc};
    assign v1_init    = {{32{r_fine[31]}}, r_fine} - FINE_OFFSET;
    assign p6_v1      = $signed(r_prod) >>> 33;
    assign prod_asr14 = $signed(r_prod) >>> 14;
    assign prod_asr19 = $signed(r_prod) >>> 19;
    assign num_base   = ((ADC_FULL - adc64) << 31) - r_v2;
    assign p_sum      = r_p + r_x + prod_asr19;
    assign final_p    = $unsigned($signed(p_sum) >>> 8) + (p7 << 4);
    assign t5         = (r_x << 2) + r_x + 64'd128;

    assign rem_sh = {r_rem, r_quo[63]};
    assign div_ge = rem_sh >= {1'b0, r_dv};

    assign s_accept = s_tvalid && s_tready;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || m_tready);

    // Next state and multiplier return point
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    if (s_tuser == KIND_TEMP) n_state = r_temp_en ? S_T0 : S_OUT;
                    else                      n_state = r_press_en ? S_P0 : S_OUT;
                end
            end
            S_T0:  begin n_state = S_MUL; n_ret = S_T1;  end
            S_T1:  begin n_state = S_MUL; n_ret = S_T2;  end
            S_T2:  begin n_state = S_MUL; n_ret = S_T3;  end
            S_T3:  n_state = S_T4;
            S_T4:  n_state = S_OUT;
            S_P0:  begin n_state = S_MUL; n_ret = S_P1;  end
            S_P1:  begin n_state = S_MUL; n_ret = S_P2;  end
            S_P2:  begin n_state = S_MUL; n_ret = S_P3;  end
            S_P3:  begin n_state = S_MUL; n_ret = S_P4;  end
            S_P4:  begin n_state = S_MUL; n_ret = S_P5;  end
            S_P5:  begin n_state = S_MUL; n_ret = S_P6;  end
            S_P6: begin
                if (p6_v1 == 64'd0) n_state = S_OUT;
                else begin
                    n_state = S_MUL;
                    n_ret   = S_P7;
                end
            end
            S_P7:  n_state = S_DIV;
            S_DIV: if (r_cnt == 6'd63) n_state = S_P8;
            S_P8:  n_state = S_P9;
            S_P9:  begin n_state = S_MUL; n_ret = S_P10; end
            S_P10: begin n_state = S_MUL; n_ret = S_P11; end
            S_P11: begin n_state = S_MUL; n_ret = S_P12; end
            S_P12: n_state = S_P13;
            S_P13: n_state = S_OUT;
            S_MUL: if (r_mb == 64'd0) n_state = r_ret;
            S_OUT: if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready = (r_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ret      <= S_IDLE;
            r_cal_t    <= '0;
            r_cal_p1   <= '0;
            r_cal_p2   <= '0;
            r_cal_p9   <= '0;
            r_temp_en  <= 1'b1;
            r_press_en <= 1'b1;
            r_fine     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_CALIB_TEMP:   r_cal_t    <= i_cfg_wdata[47:0];
                    REG_CALIB_PRESS1: r_cal_p1   <= i_cfg_wdata;
                    REG_CALIB_PRESS2: r_cal_p2   <= i_cfg_wdata;
                    REG_CALIB_PRESS9: r_cal_p9   <= i_cfg_wdata[15:0];
                    REG_TEMP_EN:      r_temp_en  <= i_cfg_wdata[0];
                    REG_PRESS_EN:     r_press_en <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (r_state == S_T4) r_fine <= r_x[31:0];
            if (out_load)              r_out_valid <= 1'b1;
            else if (m_tready)         r_out_valid <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_t    <= r_res_t;
            r_out_p    <= r_res_p;
            r_out_st   <= r_res_st;
            r_out_kind <= r_kind;
        end
        case (r_state)
            S_IDLE: begin
                r_adc   <= s_tdata[23:4];
                r_kind  <= s_tuser;
                r_res_t <= '0;
                r_res_p <= '0;
                r_res_st <= ((s_tuser == KIND_TEMP) ? r_temp_en : r_press_en)
                            ? STATUS_OK : STATUS_DISABLED;
            end
            S_T0: begin
                r_prod <= '0;
                r_ma   <= (adc64 >> 3) - (t1 << 1);
                r_mb   <= t2;
            end
            S_T1: begin
                r_x    <= $signed(r_prod) >>> 11;
                r_prod <= '0;
                r_ma   <= (adc64 >> 4) - t1;
                r_mb   <= (adc64 >> 4) - t1;
            end
            S_T2: begin
                r_prod <= '0;
                r_ma   <= $signed(r_prod) >>> 12;
                r_mb   <= t3;
            end
            S_T3: r_x <= r_x + prod_asr14;
            S_T4: r_res_t <= 32'($signed(t5) >>> 8);
            S_P0: begin
                r_v1   <= v1_init;
                r_prod <= '0;
                r_ma   <= v1_init;
                r_mb   <= v1_init;
            end
            S_P1: begin
                r_sq   <= r_prod;
                r_prod <= '0;
                r_ma   <= r_prod;
                r_mb   <= p6;
            end
            S_P2: begin
                r_v2   <= r_prod;
                r_prod <= '0;
                r_ma   <= r_v1;
                r_mb   <= p5;
            end
            S_P3: begin
                r_v2   <= r_v2 + (r_prod << 17) + (p4 << 35);
                r_prod <= '0;
                r_ma   <= r_sq;
                r_mb   <= p3;
            end
            S_P4: begin
                r_x    <= $signed(r_prod) >>> 8;
                r_prod <= '0;
                r_ma   <= r_v1;
                r_mb   <= p2;
            end
            S_P5: begin
                r_prod <= '0;
                r_ma   <= r_x + (r_prod << 12) + (64'd1 << 47);
                r_mb   <= p1;
            end
            S_P6: begin
                r_v1 <= p6_v1;
                if (p6_v1 == 64'd0) r_res_st <= STATUS_DIV_ZERO;
                r_prod <= '0;
                r_ma   <= num_base;
                r_mb   <= PRESS_SCALE;
            end
            S_P7: begin
                // Work on magnitudes; fix the sign at the end
                r_qneg <= r_prod[63] ^ r_v1[63];
                r_quo  <= r_prod[63] ? (64'd0 - r_prod) : r_prod;
                r_dv   <= r_v1[63] ? (64'd0 - r_v1) : r_v1;
                r_rem  <= '0;
                r_cnt  <= '0;
            end
            S_DIV: begin
                r_rem <= div_ge ? 64'(rem_sh - {1'b0, r_dv}) : rem_sh[63:0];
                r_quo <= {r_quo[62:0], div_ge};
                r_cnt <= r_cnt + 6'd1;
            end
            S_P8: r_p <= r_qneg ? (64'd0 - r_quo) : r_quo;
            S_P9: begin
                r_prod <= '0;
                r_ma   <= $signed(r_p) >>> 13;
                r_mb   <= p9;
            end
            S_P10: begin
                r_ma   <= r_prod;
                r_prod <= '0;
                r_mb   <= $signed(r_p) >>> 13;
            end
            S_P11: begin
                r_x    <= $signed(r_prod) >>> 25;
                r_prod <= '0;
                r_ma   <= r_p;
                r_mb   <= p8;
            end
            S_P12: r_x <= final_p;
            S_P13: begin
                if (r_x[63])                 r_res_p <= '0;
                else if (r_x[63:32] != '0)   r_res_p <= '1;
                else                         r_res_p <= r_x[31:0];
            end
            S_MUL: begin
                if (r_mb[0]) r_prod <= r_prod + r_ma;
                r_ma <= r_ma << 1;
                r_mb <= r_mb >> 1;
            end
            default: ;
        endcase
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out_kind;
    assign m_tdata  = {6'd0, r_out_st, r_out_p, r_out_t};

    a_fine_only_from_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_fine) |-> $past(r_state) == S_T4)
        else $error("fine temperature changed outside temperature path");

    a_no_div_zero_on_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser == KIND_TEMP) |-> m_tdata[65:64] != STATUS_DIV_ZERO)
        else $error("divisor status on temperature result");

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready |-> (r_state == S_IDLE))
        else $error("request taken while busy");

endmodule

/* sim/tb.sv */
// Testbench for baro_temp_pressure_compensation_core: directed table plus random readings,
// checked against an in-bench compensation predictor. Depends on btpc_pkg and the core.
`timescale 1ns / 100ps

module tb;
    import btpc_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [31:0] temp_centi;
        logic [31:0] press_q24_8;
        logic [1:0]  status;
    } t_comp_result;

    typedef struct {
        logic        op;
        logic [23:0] raw;
        logic        known;
        logic [31:0] temp_centi;
        logic [31:0] press_q24_8;
        logic [1:0]  status;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // [23:0] raw_reading
    logic        s_tuser = 1'b0; // [0] opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;        // [31:0] temp, [63:32] pressure, [65:64] status
    logic        m_tuser;        // [0] kind

    baro_temp_pressure_compensation_core dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    logic [47:0] cal_t;
    logic [63:0] cal_p1, cal_p2;
    logic [15:0] cal_p9;
    logic        en_t, en_p;
    logic [31:0] fine_t;

    t_comp_result pending_results[$];
    int  errors = 0;
    bit  rx_idle_off = 0;
    int  rx_stall = 0;

    function automatic logic signed [63:0] sx16(input logic [15:0] x);
        return {{48{x[15]}}, x};
    endfunction

    function automatic t_comp_result compensate(input logic op, input logic [23:0] raw);
        t_comp_result r;
        logic signed [63:0] adc, t1, t2, t3, a, v1, v2, d, t, p, h;
        logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, mn, md;
        logic [63:0] q;
        r = '0;
        r.kind = op;
        adc = {44'd0, raw[23:4]};
        if (op == KIND_TEMP) begin
            if (!en_t) begin
                r.status = STATUS_DISABLED;
            end else begin
                t1 = {48'd0, cal_t[15:0]};
                t2 = sx16(cal_t[31:16]);
                t3 = sx16(cal_t[47:32]);
                a  = ((adc >>> 3) - (t1 <<< 1)) * t2;
                v1 = a >>> 11;
                d  = (adc >>> 4) - t1;
                v2 = ((d * d) >>> 12) * t3 >>> 14;
                t  = v1 + v2;
                fine_t = t[31:0];
                a = (t * 5 + 128) >>> 8;
                r.temp_centi = a[31:0];
            end
        end else if (!en_p) begin
            r.status = STATUS_DISABLED;
        end else begin
            p1 = {48'd0, cal_p1[15:0]};
            p2 = sx16(cal_p1[31:16]); p3 = sx16(cal_p1[47:32]); p4 = sx16(cal_p1[63:48]);
            p5 = sx16(cal_p2[15:0]);  p6 = sx16(cal_p2[31:16]);
            p7 = sx16(cal_p2[47:32]); p8 = sx16(cal_p2[63:48]);
            p9 = sx16(cal_p9);
            v1 = {{32{fine_t[31]}}, fine_t} - 64'sd128000;
            v2 = v1 * v1 * p6;
            v2 = v2 + ((v1 * p5) <<< 17);
            v2 = v2 + (p4 <<< 35);
            v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
            v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
            if (v1 == 0) begin
                r.status = STATUS_DIV_ZERO;
            end else begin
                p = 64'sd1048576 - adc;
                p = ((p <<< 31) - v2) * 3125;
                mn = p[63] ? -p : p;
                md = v1[63] ? -v1 : v1;
                q = $unsigned(mn) / $unsigned(md);
                p = (p[63] != v1[63]) ? -$signed(q) : $signed(q);
                h = p >>> 13;
                v1 = (p9 * h * h) >>> 25;
                v2 = (p8 * p) >>> 19;
                p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
                if (p < 0) r.press_q24_8 = '0;
                else if (p > 64'sh0FFFFFFFF) r.press_q24_8 = '1;
                else r.press_q24_8 = p[31:0];
            end
        end
        return r;
    endfunction

    task automatic write_reg(input t_reg_index idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            REG_CALIB_TEMP:   cal_t  = val[47:0];
            REG_CALIB_PRESS1: cal_p1 = val;
            REG_CALIB_PRESS2: cal_p2 = val;
            REG_CALIB_PRESS9: cal_p9 = val[15:0];
            REG_TEMP_EN:      en_t   = val[0];
            REG_PRESS_EN:     en_p   = val[0];
            default: ;
        endcase
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Typical calibration words, around the data-sheet example values.
    task automatic load_typical();
        write_reg(REG_CALIB_TEMP, {16'd0, 16'hFC18, 16'd26435, 16'd27504});
        write_reg(REG_CALIB_PRESS1, {16'd2855, 16'd8173, 16'hD5D0, 16'd36477});
        write_reg(REG_CALIB_PRESS2, {16'hEC38, 16'd15500, 16'hFFF9, 16'd140});
        write_reg(REG_CALIB_PRESS9, 64'd6000);
    endtask

    // Hold valid after a request is taken; the next send or drain moves it.
    task automatic send(input logic op, input logic [23:0] raw, input bit gaps,
                        input t_stim_row row, input bit use_row);
        t_comp_result r;
        if (gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= raw;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        r = compensate(op, raw);
        if (use_row && row.known) begin
            r.temp_centi = row.temp_centi;
            r.press_q24_8 = row.press_q24_8;
            r.status = row.status;
        end
        pending_results.insert(pending_results.size(), r);
    endtask

    // output side: random stall bursts, sampled at the edge
    always @(posedge i_clk) begin
        t_comp_result e;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result with no request pending");
                    errors++;
                end else begin
                    e = pending_results.pop_front();
                    if (m_tuser !== e.kind) begin
                        $error("kind exp %0d got %0d", e.kind, m_tuser); errors++;
                    end
                    if (m_tdata[31:0] !== e.temp_centi) begin
                        $error("temperature_centi exp %0d got %0d",
                               $signed(e.temp_centi), $signed(m_tdata[31:0])); errors++;
                    end
                    if (m_tdata[63:32] !== e.press_q24_8) begin
                        $error("pressure_q24_8 exp %0d got %0d",
                               e.press_q24_8, m_tdata[63:32]); errors++;
                    end
                    if (m_tdata[65:64] !== e.status) begin
                        $error("status exp %0d got %0d", e.status, m_tdata[65:64]); errors++;
                    end
                end
            end
            if (rx_idle_off) begin
                m_tready <= 1'b1;
            end else if (rx_stall > 0) begin
                m_tready <= 1'b0;
                rx_stall--;
            end else if ($urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                rx_stall = $urandom_range(0, 8);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        t_stim_row rows[$];
        t_stim_row row;
        int n;
        logic [63:0] w;
        cal_t = '0; cal_p1 = '0; cal_p2 = '0; cal_p9 = '0;
        en_t = 1; en_p = 1; fine_t = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // After reset all calibration is zero: temperature gives 0, pressure divisor is zero.
        rows.insert(rows.size(), '{KIND_TEMP,  24'h000000, 1, 32'd0, 32'd0, STATUS_OK});
        rows.insert(rows.size(), '{KIND_TEMP,  24'hFFFFFF, 1, 32'd0, 32'd0, STATUS_OK});
        rows.insert(rows.size(), '{KIND_PRESS, 24'h000000, 1, 32'd0, 32'd0, STATUS_DIV_ZERO});
        rows.insert(rows.size(), '{KIND_PRESS, 24'hFFFFFF, 1, 32'd0, 32'd0, STATUS_DIV_ZERO});
        foreach (rows[i]) send(rows[i].op, rows[i].raw, 0, rows[i], 1);
        drain();

        load_typical();
        rows.delete();
        rows.insert(rows.size(), '{KIND_TEMP,  24'h7E_ED_00, 0, 0, 0, 0});
        rows.insert(rows.size(), '{KIND_PRESS, 24'h65_5A_C0, 0, 0, 0, 0});
        rows.insert(rows.size(), '{KIND_TEMP,  24'h000000, 0, 0, 0, 0});
        rows.insert(rows.size(), '{KIND_PRESS, 24'h000000, 0, 0, 0, 0});
        rows.insert(rows.size(), '{KIND_PRESS, 24'hFFFFFF, 0, 0, 0, 0});
        rows.insert(rows.size(), '{KIND_TEMP,  24'hFFFFFF, 0, 0, 0, 0});
        rows.insert(rows.size(), '{KIND_PRESS, 24'h00000F, 0, 0, 0, 0});
        foreach (rows[i]) send(rows[i].op, rows[i].raw, 1, rows[i], 0);
        drain();

        // Disabled channels give 0 with disabled status and keep fine temperature.
        write_reg(REG_TEMP_EN, 64'd0);
        write_reg(REG_PRESS_EN, 64'd0);
        row = '{KIND_TEMP, 24'h123450, 1, 32'd0, 32'd0, STATUS_DISABLED};
        send(row.op, row.raw, 0, row, 1);
        row = '{KIND_PRESS, 24'h654320, 1, 32'd0, 32'd0, STATUS_DISABLED};
        send(row.op, row.raw, 0, row, 1);
        drain();
        write_reg(REG_PRESS_EN, 64'd1);
        send(KIND_PRESS, 24'h500000, 0, row, 0);
        drain();
        write_reg(REG_TEMP_EN, 64'd1);

        // Extreme calibration words: saturation and negative pressure.
        write_reg(REG_CALIB_TEMP, 64'hFFFF_FFFF_FFFF);
        write_reg(REG_CALIB_PRESS1, 64'h7FFF_8000_7FFF_FFFF);
        write_reg(REG_CALIB_PRESS2, 64'h7FFF_8000_7FFF_8000);
        write_reg(REG_CALIB_PRESS9, 64'h8000);
        send(KIND_TEMP, 24'hFFFFFF, 0, row, 0);
        send(KIND_PRESS, 24'h000000, 0, row, 0);
        send(KIND_PRESS, 24'hFFFFFF, 0, row, 0);
        drain();
        write_reg(REG_CALIB_PRESS2, 64'h8000_7FFF_8000_7FFF);
        write_reg(REG_CALIB_PRESS9, 64'h7FFF);
        send(KIND_TEMP, 24'h000000, 0, row, 0);
        send(KIND_PRESS, 24'h800000, 0, row, 0);
        drain();

        // Random phases: mostly plausible calibrations, some fully random.
        for (int ph = 0; ph < 11; ph++) begin
            if (ph % 3 == 0) begin
                w = {$urandom, $urandom};
                write_reg(REG_CALIB_TEMP, w);
                write_reg(REG_CALIB_PRESS1, {$urandom, $urandom});
                write_reg(REG_CALIB_PRESS2, {$urandom, $urandom});
                write_reg(REG_CALIB_PRESS9, {48'd0, 16'($urandom)});
            end else begin
                load_typical();
                write_reg(REG_CALIB_TEMP, {16'd0, 16'($urandom_range(0, 65535) | 16'hF000),
                          16'($urandom_range(20000, 30000)), 16'($urandom_range(20000, 32000))});
            end
            write_reg(REG_TEMP_EN, 64'($urandom_range(0, 7) != 0));
            write_reg(REG_PRESS_EN, 64'($urandom_range(0, 7) != 0));
            if (ph == 10) rx_idle_off = 1;
            n = 100;
            for (int k = 0; k < n; k++)
                send((k % 2 == 1) ? KIND_PRESS : ((k % 7 == 3) ? KIND_PRESS : KIND_TEMP),
                     24'($urandom), ph != 10, row, 0);
            // hold the sender until all pending results arrive
            drain();
        end

        if (errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    initial begin
        #20000000;
        $display("FAILURE");
        $finish;
    end
endmodule
